// ===== hw/rtl/svpt_pkg.sv =====
// Shared constants, types and codes for the Sv39 page table map/walk block.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package svpt_pkg;

  // Store geometry. Table pages are 512 entries of 64 bits each.
  localparam int TABLE_PAGES      = 64;
  localparam int IDX_W            = 9;
  localparam int ENTRIES_PER_PAGE = 1 << IDX_W;
  localparam int PAGE_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFT_W            = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W           = PAGE_W + IDX_W;
  localparam int DEPTH            = TABLE_PAGES * ENTRIES_PER_PAGE;

  // Field widths of the request and response words.
  localparam int VPN_W  = 27;
  localparam int PPN_W  = 44;
  localparam int PERM_W = 8;
  localparam int PTE_W  = 64;

  // Page table entry layout.
  localparam int PTE_SHIFT = 10;
  localparam int TGT_W     = PTE_W - PTE_SHIFT;
  localparam logic [PTE_W-1:0] PTE_V_MASK      = PTE_W'(64'h01);
  localparam logic [PTE_W-1:0] PTE_LEAF_FLAGS  = PTE_W'(64'hC1);

  // Walk levels.
  localparam int LVL_W = 2;
  localparam logic [LVL_W-1:0] TOP_LEVEL  = LVL_W'(2);
  localparam logic [LVL_W-1:0] LEAF_LEVEL = LVL_W'(0);

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NOT_MAPPED    = 2'd1,
    ST_OUT_OF_TABLES = 2'd2,
    ST_DOUBLE_MAP    = 2'd3
  } svpt_status_t;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_MAP    = 1'b1
  } svpt_req_type_t;

  typedef enum logic [2:0] {
    WS_CLEAR,
    WS_IDLE,
    WS_READ,
    WS_EVAL,
    WS_DONE
  } svpt_walk_state_t;

  // Captured request word.
  typedef struct packed {
    svpt_req_type_t    req_type;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
    logic [PERM_W-1:0] perm;
  } svpt_req_t;

  // Finished walk result handed to the output register.
  typedef struct packed {
    logic             valid;
    svpt_status_t     status;
    logic [PTE_W-1:0] leaf;
  } svpt_rsp_t;

  // Single port access to the table store.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [PTE_W-1:0]  wdata;
  } svpt_mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/svpt_store.sv =====
// Table store: synchronous single-port memory of all table pages.
// Depends on svpt_pkg for its geometry and the access struct.
`default_nettype none

module svpt_store (
  input  wire logic                    clk,
  input  wire svpt_pkg::svpt_mem_req_t mem_req,
  output logic [svpt_pkg::PTE_W-1:0]   rd_data
);
  import svpt_pkg::*;

  logic [PTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/svpt_walk.sv =====
// Walk sequencer: clears the store after reset, then walks and maps one
// request at a time through read-evaluate-write steps. Depends on svpt_pkg.
`default_nettype none

module svpt_walk (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire svpt_pkg::svpt_req_t     req,
  input  wire logic                    res_take,
  input  wire logic [svpt_pkg::PTE_W-1:0] rd_data,
  output logic                         idle,
  output svpt_pkg::svpt_mem_req_t      mem_req,
  output svpt_pkg::svpt_rsp_t          rsp
);
  import svpt_pkg::*;

  svpt_walk_state_t  state, state_next;
  logic [LVL_W-1:0]  level;
  logic [PAGE_W-1:0] page;
  logic [NFT_W-1:0]  next_free;
  logic [ADDR_W-1:0] clr_addr;
  svpt_status_t      res_status;
  logic [PTE_W-1:0]  res_leaf;

  logic [IDX_W-1:0]  idx;
  logic              is_leaf_lvl;
  logic              ent_ok;
  logic              pool_empty;
  logic              is_map;
  logic              go_down;
  logic              alloc;
  logic              leaf_wr;
  logic              clr_last;
  svpt_status_t      eval_status;
  logic [PTE_W-1:0]  eval_leaf;
  logic [PTE_W-1:0]  new_leaf;
  logic [PTE_W-1:0]  new_dir;

  // Index field of the virtual page number for the current level.
  always_comb begin
    case (level)
      TOP_LEVEL:    idx = req.vpn[3*IDX_W-1:2*IDX_W];
      LVL_W'(1):    idx = req.vpn[2*IDX_W-1:IDX_W];
      default:      idx = req.vpn[IDX_W-1:0];
    endcase
  end

  // Decisions on the entry just read.
  always_comb begin
    is_map      = (req.req_type == REQ_MAP);
    is_leaf_lvl = (level == LEAF_LEVEL);
    ent_ok      = rd_data[0] && (rd_data[PTE_W-1:PTE_SHIFT] < TGT_W'(TABLE_PAGES));
    pool_empty  = (next_free >= NFT_W'(TABLE_PAGES));
    alloc       = !is_leaf_lvl && !ent_ok && is_map && !pool_empty;
    go_down     = !is_leaf_lvl && (ent_ok || alloc);
    leaf_wr     = is_leaf_lvl && is_map && !rd_data[0];
    new_leaf    = (PTE_W'(req.ppn) << PTE_SHIFT) | PTE_W'(req.perm) | PTE_LEAF_FLAGS;
    new_dir     = (PTE_W'(next_free[PAGE_W-1:0]) << PTE_SHIFT) | PTE_V_MASK;
    clr_last    = (clr_addr == ADDR_W'(DEPTH - 1));

    eval_status = ST_OK;
    eval_leaf   = '0;
    if (!is_leaf_lvl) begin
      if (!ent_ok && !is_map) begin
        eval_status = ST_NOT_MAPPED;
      end else if (!ent_ok && pool_empty) begin
        eval_status = ST_OUT_OF_TABLES;
      end
    end else if (!is_map) begin
      eval_leaf = rd_data;
    end else if (rd_data[0]) begin
      eval_status = ST_DOUBLE_MAP;
    end else begin
      eval_leaf = new_leaf;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      WS_CLEAR: if (clr_last) state_next = WS_IDLE;
      WS_IDLE:  if (start) state_next = WS_READ;
      WS_READ:  state_next = WS_EVAL;
      WS_EVAL:  state_next = go_down ? WS_READ : WS_DONE;
      WS_DONE:  if (res_take) state_next = WS_IDLE;
      default:  state_next = WS_CLEAR;
    endcase
  end

  // Outputs: store access and status toward the top level.
  always_comb begin
    mem_req.rd_en = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = {page, idx};
    mem_req.wdata = new_leaf;
    unique case (state)
      WS_CLEAR: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = clr_addr;
        mem_req.wdata = '0;
      end
      WS_READ: begin
        mem_req.rd_en = 1'b1;
      end
      WS_EVAL: begin
        mem_req.wr_en = alloc || leaf_wr;
        mem_req.wdata = alloc ? new_dir : new_leaf;
      end
      default: begin
      end
    endcase
    idle       = (state == WS_IDLE);
    rsp.valid  = (state == WS_DONE);
    rsp.status = res_status;
    rsp.leaf   = res_leaf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= WS_CLEAR;
      clr_addr  <= '0;
      next_free <= NFT_W'(1);
    end else begin
      state <= state_next;
      if (state == WS_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == WS_EVAL && alloc) begin
        next_free <= next_free + NFT_W'(1);
      end
    end
  end

  // Walk position and result; these need no reset.
  always_ff @(posedge clk) begin
    if (state == WS_IDLE && start) begin
      level <= TOP_LEVEL;
      page  <= '0;
    end else if (state == WS_EVAL) begin
      if (go_down) begin
        level <= level - LVL_W'(1);
        page  <= alloc ? next_free[PAGE_W-1:0] : rd_data[PTE_SHIFT+PAGE_W-1:PTE_SHIFT];
      end else begin
        res_status <= eval_status;
        res_leaf   <= eval_leaf;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sv39_page_table_map_walk.sv =====
// Top level of the Sv39 page table map/walk block: request capture, output
// register, walk sequencer and table store. Depends on svpt_pkg, svpt_walk, svpt_store.
`default_nettype none

// The block keeps a three-level Sv39 page table in an internal store of
// TABLE_PAGES table pages of 512 entries, with the root at page 0. Each request
// word is a lookup (req_type 0) or a one-page map (req_type 1); each produces
// exactly one response word with a status and the leaf entry found or written.
// After reset the block sweeps the whole store to zero, one entry per cycle,
// over TABLE_PAGES*512 entries (32768 with the default size); req_stall
// stays high during that pass. A request then runs through a start step, a
// read and an evaluate step per level walked (a read of the single-port store,
// whose data is registered, then an evaluate step that may write the same
// entry back) and a final step that hands over its result. A walk stops early
// at a missing intermediate level. The steps run in sequence, since the store
// has a single port and every step depends on the entry read before.
// Requests are taken one at a time, but a new request is accepted while the
// previous response still waits in the output register.
module sv39_page_table_map_walk (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic                        req_type,
  input  wire logic [svpt_pkg::VPN_W-1:0]  vpn,
  input  wire logic [svpt_pkg::PPN_W-1:0]  ppn,
  input  wire logic [svpt_pkg::PERM_W-1:0] perm,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [1:0]                       status,
  output logic [svpt_pkg::PTE_W-1:0]       leaf_entry
);
  import svpt_pkg::*;

  svpt_req_t        req;
  svpt_rsp_t        walk_rsp;
  svpt_mem_req_t    mem_req;
  logic [PTE_W-1:0] rd_data;
  logic             walk_idle;
  logic             accept;
  logic             res_take;

  // The walker only starts a new request from its idle state, so the stall
  // toward the requester follows it directly.
  assign req_stall = !walk_idle;
  assign accept    = req_valid && !req_stall;

  // The output register may load whenever it is empty or being drained.
  assign res_take  = !rsp_valid || !rsp_stall;

  // The request word is held for the whole walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.req_type <= svpt_req_type_t'(req_type);
      req.vpn      <= vpn;
      req.ppn      <= ppn;
      req.perm     <= perm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (walk_rsp.valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_rsp.valid && res_take) begin
      status     <= walk_rsp.status;
      leaf_entry <= walk_rsp.leaf;
    end
  end

  svpt_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .req      (req),
    .res_take (res_take),
    .rd_data  (rd_data),
    .idle     (walk_idle),
    .mem_req  (mem_req),
    .rsp      (walk_rsp)
  );

  svpt_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
